>>> rtl/lvim_pkg.sv
// ----------------------------------------------------------------------------
// lvim_pkg
// Shared types and constants for the LBA version invalidation map.
// ----------------------------------------------------------------------------
package lvim_pkg;

    localparam int LBA_W = 16;
    localparam int VER_W = 8;
    localparam int CNT_W = 17;

    localparam logic [VER_W-1:0] UNMAPPED    = '1;
    localparam logic [VER_W-1:0] MAX_VER_RST = UNMAPPED - 1'b1;
    localparam logic [CNT_W-1:0] COUNT_MAX   = '1;

    typedef enum logic [1:0] {
        FUNC_MAP    = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_DEC    = 2'd2,
        FUNC_READ   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_UPDATE
    } t_state;

    typedef struct packed {
        t_func              func;
        logic [LBA_W-1:0]   lba;
        logic [VER_W-1:0]   version_id;
        logic [CNT_W-1:0]   amount;
    } t_in_item;

    typedef struct packed {
        logic [VER_W-1:0]   old_version;
        logic [CNT_W-1:0]   count;
        logic               error;
    } t_out_item;

endpackage

>>> rtl/lvim_ram.sv
// ----------------------------------------------------------------------------
// lvim_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lvim_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/lba_version_invalidation_map_unit.sv
// ----------------------------------------------------------------------------
// lba_version_invalidation_map_unit
// Per-LBA version map with per-version invalidation counters.
// ----------------------------------------------------------------------------
// After reset the block sweeps the map to unmapped and the counters to zero
// (one map entry per cycle), and accepts no transaction until that is done.
// Transactions are handled one at a time: lookup, decrease, read and a
// rejected map finish in the read state and return to idle, any other map
// goes on to an update state, since it needs the map read before it can
// read and update the old version's counter through the single counter
// read port. A finished result sits in the output register while the next
// transaction is accepted; a new result that finds that register still full
// holds the block in place until the register drains.
module lba_version_invalidation_map_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lvim_pkg::VER_W-1:0]       i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  lvim_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output lvim_pkg::t_out_item              o_out_data
);

    import lvim_pkg::*;

    t_state             r_state, n_state;
    t_in_item           r_item, n_item;
    logic [VER_W-1:0]   r_old, n_old;
    logic [CNT_W-1:0]   r_cnt_ver, n_cnt_ver;
    logic [LBA_W-1:0]   r_clr_addr, n_clr_addr;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out_data, n_out_data;
    logic [VER_W-1:0]   r_ver_limit;

    logic               tbl_we, tbl_re;
    logic [LBA_W-1:0]   tbl_waddr;
    logic [VER_W-1:0]   tbl_wdata, tbl_q;
    logic               cnt_we, cnt_re;
    logic [VER_W-1:0]   cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]   cnt_wdata, cnt_q;

    logic               out_free, accept, ver_real;
    logic               res_valid;
    t_out_item          res;

    lvim_ram #(.ADDR_W(LBA_W), .DATA_W(VER_W)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (tbl_re),
        .i_raddr (i_in_data.lba),
        .o_rdata (tbl_q)
    );

    lvim_ram #(.ADDR_W(VER_W), .DATA_W(CNT_W)) u_cnt (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_q)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign ver_real   = (r_item.version_id != UNMAPPED) &&
                        (r_item.version_id <= r_ver_limit);

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_old       = r_old;
        n_cnt_ver   = r_cnt_ver;
        n_clr_addr  = r_clr_addr;
        tbl_we      = 1'b0;
        tbl_re      = 1'b0;
        tbl_waddr   = r_item.lba;
        tbl_wdata   = r_item.version_id;
        cnt_we      = 1'b0;
        cnt_re      = 1'b0;
        cnt_waddr   = r_item.version_id;
        cnt_wdata   = '0;
        cnt_raddr   = i_in_data.version_id;
        res_valid   = 1'b0;
        res         = '{old_version: UNMAPPED, count: '0, error: 1'b0};

        unique case (r_state)
            S_CLEAR: begin
                tbl_we     = 1'b1;
                tbl_waddr  = r_clr_addr;
                tbl_wdata  = UNMAPPED;
                cnt_we     = 1'b1;
                cnt_waddr  = r_clr_addr[VER_W-1:0];
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_item  = i_in_data;
                    tbl_re  = 1'b1;
                    cnt_re  = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                unique case (r_item.func)
                    FUNC_MAP: begin
                        if (r_item.version_id != UNMAPPED && !ver_real) begin
                            res = '{old_version: tbl_q, count: '0, error: 1'b1};
                            res_valid = out_free;
                        end else begin
                            tbl_we    = 1'b1;
                            n_old     = tbl_q;
                            n_cnt_ver = ver_real ? cnt_q : '0;
                            cnt_re    = 1'b1;
                            cnt_raddr = tbl_q;
                            n_state   = S_UPDATE;
                        end
                    end
                    FUNC_LOOKUP: begin
                        res = '{old_version: tbl_q, count: '0, error: 1'b0};
                        res_valid = out_free;
                    end
                    FUNC_DEC: begin
                        res_valid = out_free;
                        if (!ver_real) begin
                            res.error = 1'b1;
                        end else if (cnt_q < r_item.amount) begin
                            res.error = 1'b1;
                            res.count = cnt_q;
                        end else begin
                            cnt_wdata = cnt_q - r_item.amount;
                            cnt_we    = out_free;
                            res.count = cnt_wdata;
                        end
                    end
                    FUNC_READ: begin
                        res_valid = out_free;
                        if (!ver_real) begin
                            res.error = 1'b1;
                        end else begin
                            res.count = cnt_q;
                        end
                    end
                    default: ;
                endcase
                if (res_valid) begin
                    n_state = S_IDLE;
                end
            end
            S_UPDATE: begin
                cnt_waddr = r_old;
                cnt_wdata = cnt_q + 1'b1;
                res = '{old_version: r_old, count: r_cnt_ver, error: 1'b0};
                if (out_free) begin
                    res_valid = 1'b1;
                    cnt_we    = (r_old != UNMAPPED) && (r_old != r_item.version_id) &&
                                (cnt_q != COUNT_MAX);
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        if (res_valid) begin
            n_out_valid = 1'b1;
            n_out_data  = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_ver_limit <= MAX_VER_RST;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_ver_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_old      <= n_old;
        r_cnt_ver  <= n_cnt_ver;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lba_version_invalidation_map_unit. A queue of host
// transactions feeds a valid/ready driver. A monitor predicts every accepted
// transaction against a local copy of the LBA map and the invalidation
// counters, then checks each returned result field by field. The run covers
// directed corner cases and random traffic under several max_version settings.
// ----------------------------------------------------------------------------
module tb;
    import lvim_pkg::*;

    localparam int STALL_LIMIT = 300000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_data;

    logic        throttle = 1'b1;
    int          err_count = 0;
    int          stall_cycles = 0;

    logic [7:0]  lba_map [65536];
    logic [16:0] inval_cnt [256];
    logic [7:0]  max_ver;

    t_in_item    host_ops [$];
    t_out_item   due_results [$];

    lba_version_invalidation_map_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic usable_version(logic [7:0] v);
        return v != UNMAPPED && v <= max_ver;
    endfunction

    function automatic t_out_item lvim_response(t_in_item op);
        t_out_item  r;
        logic [7:0] prev;
        r.old_version = UNMAPPED;
        r.count = '0;
        r.error = 1'b0;
        if (op.func == FUNC_MAP || op.func == FUNC_LOOKUP) begin
            prev = lba_map[op.lba];
            r.old_version = prev;
            if (op.func == FUNC_MAP) begin
                if (op.version_id != UNMAPPED && !usable_version(op.version_id)) begin
                    r.error = 1'b1;
                end else begin
                    if (prev != UNMAPPED && prev != op.version_id &&
                        inval_cnt[prev] != COUNT_MAX) begin
                        inval_cnt[prev] = inval_cnt[prev] + 1'b1;
                    end
                    lba_map[op.lba] = op.version_id;
                end
                if (usable_version(op.version_id)) begin
                    r.count = inval_cnt[op.version_id];
                end
            end
        end else if (!usable_version(op.version_id)) begin
            r.error = 1'b1;
        end else begin
            if (op.func == FUNC_DEC) begin
                if (inval_cnt[op.version_id] < op.amount) begin
                    r.error = 1'b1;
                end else begin
                    inval_cnt[op.version_id] = inval_cnt[op.version_id] - op.amount;
                end
            end
            r.count = inval_cnt[op.version_id];
        end
        return r;
    endfunction

    function automatic t_in_item host_op(t_func f, logic [15:0] lba, logic [7:0] ver,
                                         logic [16:0] amt);
        t_in_item op;
        op.func = f;
        op.lba = lba;
        op.version_id = ver;
        op.amount = amt;
        return op;
    endfunction

    task automatic queue_op(input t_in_item op);
        host_ops.insert(host_ops.size(), op);
    endtask

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("mismatch: %s", msg);
    endtask

    task automatic wait_drained();
        while (host_ops.size() != 0 || in_valid || due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_ver_limit(input logic [7:0] v);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        max_ver = v;
    endtask

    task automatic queue_random_ops(input int n);
        t_in_item op;
        int       r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                op.func = FUNC_MAP;
            end else if (r < 60) begin
                op.func = FUNC_LOOKUP;
            end else if (r < 80) begin
                op.func = FUNC_DEC;
            end else begin
                op.func = FUNC_READ;
            end
            r = $urandom_range(0, 99);
            if (r < 80) begin
                op.lba = 16'($urandom_range(0, 15));
            end else if (r < 88) begin
                op.lba = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end else begin
                op.lba = 16'($urandom_range(0, 65535));
            end
            r = $urandom_range(0, 99);
            if (r < 65) begin
                op.version_id = 8'($urandom_range(0, (max_ver < 3) ? max_ver : 3));
            end else if (r < 75) begin
                op.version_id = max_ver;
            end else if (r < 83) begin
                op.version_id = UNMAPPED;
            end else if (r < 90) begin
                op.version_id = max_ver + 8'd1;
            end else begin
                op.version_id = 8'($urandom_range(0, 255));
            end
            r = $urandom_range(0, 99);
            if (r < 60) begin
                op.amount = 17'($urandom_range(0, 3));
            end else if (r < 75) begin
                op.amount = '0;
            end else if (r < 90) begin
                op.amount = 17'($urandom_range(0, 131071));
            end else begin
                op.amount = $urandom_range(0, 1) ? 17'h1FFFF : 17'h10000;
            end
            queue_op(op);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (host_ops.size() != 0 && !(throttle && $urandom_range(0, 99) < 22)) begin
                in_valid <= 1'b1;
                in_data <= host_ops[0];
                host_ops.delete(0);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        out_ready <= !throttle || ($urandom_range(0, 99) >= 22);
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (out_valid && out_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result with no transaction outstanding");
                end else begin
                    want = due_results[0];
                    due_results.delete(0);
                    if (out_data.old_version !== want.old_version) begin
                        report_mismatch($sformatf("old_version got %0d expected %0d",
                                                  out_data.old_version, want.old_version));
                    end
                    if (out_data.count !== want.count) begin
                        report_mismatch($sformatf("count got %0d expected %0d",
                                                  out_data.count, want.count));
                    end
                    if (out_data.error !== want.error) begin
                        report_mismatch($sformatf("error got %0b expected %0b",
                                                  out_data.error, want.error));
                    end
                end
            end
            if (in_valid && in_ready) begin
                due_results.insert(due_results.size(), lvim_response(in_data));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[lba_version_invalidation_map_unit] ERROR");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 65536; i++) begin
            lba_map[i] = UNMAPPED;
        end
        for (int i = 0; i < 256; i++) begin
            inval_cnt[i] = '0;
        end
        max_ver = MAX_VER_RST;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_ver_limit(8'd254);
        queue_op(host_op(FUNC_LOOKUP, 16'd0, 8'd0, 17'd0));
        queue_op(host_op(FUNC_MAP, 16'd0, 8'd1, 17'd0));
        queue_op(host_op(FUNC_MAP, 16'd0, 8'd1, 17'd0));
        queue_op(host_op(FUNC_MAP, 16'd0, 8'd2, 17'd0));
        queue_op(host_op(FUNC_READ, 16'd0, 8'd1, 17'd0));
        queue_op(host_op(FUNC_DEC, 16'd0, 8'd1, 17'd2));
        queue_op(host_op(FUNC_DEC, 16'd0, 8'd1, 17'd1));
        queue_op(host_op(FUNC_DEC, 16'd0, 8'd1, 17'd0));
        queue_op(host_op(FUNC_MAP, 16'hFFFF, 8'd254, 17'd0));
        queue_op(host_op(FUNC_MAP, 16'hFFFF, UNMAPPED, 17'd0));
        queue_op(host_op(FUNC_READ, 16'd0, 8'd254, 17'd0));
        queue_op(host_op(FUNC_READ, 16'd0, UNMAPPED, 17'd0));
        queue_op(host_op(FUNC_DEC, 16'd0, UNMAPPED, 17'd0));
        queue_op(host_op(FUNC_LOOKUP, 16'hFFFF, 8'd0, 17'd0));
        queue_op(host_op(FUNC_MAP, 16'd0, UNMAPPED, 17'd0));
        queue_op(host_op(FUNC_DEC, 16'd0, 8'd2, 17'h1FFFF));
        queue_op(host_op(FUNC_DEC, 16'd0, 8'd2, 17'd1));
        queue_op(host_op(FUNC_READ, 16'd0, 8'd0, 17'd0));
        queue_op(host_op(FUNC_LOOKUP, 16'd0, 8'hFF, 17'h1FFFF));
        wait_drained();

        set_ver_limit(8'd0);
        queue_op(host_op(FUNC_MAP, 16'd5, 8'd1, 17'd0));
        queue_op(host_op(FUNC_MAP, 16'd5, 8'd0, 17'd0));
        queue_op(host_op(FUNC_READ, 16'd0, 8'd1, 17'd0));
        queue_op(host_op(FUNC_DEC, 16'd0, 8'd0, 17'd0));
        queue_op(host_op(FUNC_MAP, 16'd5, UNMAPPED, 17'd0));
        queue_op(host_op(FUNC_READ, 16'd0, 8'd0, 17'd0));
        queue_random_ops(250);
        wait_drained();

        set_ver_limit(8'd1);
        queue_random_ops(250);
        wait_drained();

        set_ver_limit(8'($urandom_range(2, 253)));
        queue_random_ops(300);
        wait_drained();

        throttle = 1'b0;
        set_ver_limit(8'd254);
        queue_random_ops(300);
        wait_drained();

        throttle = 1'b1;
        set_ver_limit(8'd127);
        queue_random_ops(300);
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (err_count == 0 && due_results.size() == 0) begin
            $display("[lba_version_invalidation_map_unit] OK");
        end else begin
            $display("[lba_version_invalidation_map_unit] ERROR");
        end
        $finish;
    end

endmodule
